[hw/rtl/box_mean_filter_top_macros.svh]
// Assertion macros shared by the box mean filter RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef BOX_MEAN_FILTER_TOP_MACROS_SVH
`define BOX_MEAN_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BMF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BMF_ASSERT(lbl, prop, msg)
`define BMF_NEVER(lbl, cond, msg)
`endif
`endif

[hw/rtl/bmf_pkg.sv]
// Shared types and constants of the box mean filter.
// No dependencies.
package bmf_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_RADIUS = 4;
	localparam int ROW_SLOTS  = 2 * MAX_RADIUS + 1;
	localparam int PIX_W      = 16;
	localparam int COL_W      = 20;
	localparam int SUM_W      = 23;
	localparam int AREA_W     = 7;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic [15:0] pixel;
		logic        padding;
		logic        frame_start;
	} in_t;

	typedef struct packed {
		logic [15:0] mean_value;
		logic [9:0]  out_column;
		logic [11:0] out_row;
		logic        last_of_frame;
	} out_t;

	typedef struct packed {
		logic shift;
		logic keep;
	} cell_ctl_t;
endpackage

[hw/rtl/box_mean_filter_top.sv]
// Box mean filter top level: line store, column-sum cell chain, divider.
// Depends on bmf_pkg, bmf_ram, bmf_cell, bmf_div and the macros header.
//
// Usage:
//   Pixels enter on the in channel (in_valid/in_ready, payload in_item) in
//   raster order over a virtual raster of (width+radius) by (height+radius)
//   positions; positions beyond the right or bottom edge carry padding=1.
//   Each request at position (c, r) with c >= radius and r >= radius yields
//   one mean on the out channel (out_valid/out_ready, payload out_item) for
//   image pixel (c-radius, r-radius); other requests yield nothing.
//   A new request is taken only when the block is idle. A request that
//   yields nothing passes through line-store read and column sum; one that
//   yields a mean also passes through the bit-serial divider (23 steps)
//   and the final step. The row sum is combinational in the column-sum step.
//   A finished mean waits in the output register while the next request is
//   taken; the block holds in its final step only if the receiver has not
//   yet taken the previous mean.
//   Reset sets width 1024, height 1024, radius 1 and the position to (0,0).
//   Registers sit at byte addresses 0, 4 and 8 of the APB port; any write
//   also returns the position to (0,0). Writes saturate to legal ranges.
module box_mean_filter_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bmf_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output bmf_pkg::out_t out_item,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import bmf_pkg::*;

	`include "box_mean_filter_top_macros.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// configuration
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [2:0]  radius_q;
	logic        cfg_wr;
	logic [10:0] wr_w;
	logic [12:0] wr_h;
	logic [2:0]  wr_r;

	// position in the virtual raster
	logic [10:0] col_q;
	logic [12:0] row_q;
	logic [3:0]  slot_q;

	logic [2:0]  state_q;
	logic        accept;

	// registered request
	logic [10:0] c_s1;
	logic [12:0] rw_s1;
	logic [3:0]  slot_s1;
	logic [15:0] pix_s1;

	logic [10:0] c_eff;
	logic [12:0] rw_eff;
	logic [3:0]  slot_eff;
	logic        in_image;
	logic [11:0] wr_lim;
	logic [13:0] hr_lim;

	logic [15:0] rd_data [ROW_SLOTS];
	logic [ROW_SLOTS-1:0] row_keep;
	logic [COL_W-1:0] col_sum;
	logic [3:0]  nrows_q;

	cell_ctl_t        cell_ctl [ROW_SLOTS];
	logic [COL_W-1:0] cell_val [ROW_SLOTS];
	logic [COL_W-1:0] cell_out [ROW_SLOTS];
	logic [COL_W-1:0] contrib [ROW_SLOTS];
	logic [ROW_SLOTS-1:0] col_keep;

	logic [SUM_W-1:0]  row_sum;
	logic [AREA_W-1:0] area_q;
	logic [7:0]        area_full;
	logic              emit;
	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  quotient;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// saturate writes into legal ranges
	always_comb begin
		wr_w = pwdata[10:0];
		if (wr_w == '0) wr_w = 11'd1;
		else if (wr_w > 11'(MAX_WIDTH)) wr_w = 11'(MAX_WIDTH);
		wr_h = pwdata[12:0];
		if (wr_h == '0) wr_h = 13'd1;
		else if (wr_h > 13'(MAX_HEIGHT)) wr_h = 13'(MAX_HEIGHT);
		wr_r = pwdata[2:0];
		if (wr_r > 3'(MAX_RADIUS)) wr_r = 3'(MAX_RADIUS);
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			REG_RADIUS: prdata = {29'd0, radius_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			radius_q <= 3'd1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= wr_w;
				REG_HEIGHT: height_q <= wr_h;
				REG_RADIUS: radius_q <= wr_r;
				default:    ;
			endcase
		end
	end

	// effective position: frame_start or an overrun wraps to the start
	assign wr_lim = {1'b0, width_q} + 12'(radius_q);
	assign hr_lim = {1'b0, height_q} + 14'(radius_q);
	always_comb begin
		c_eff    = col_q;
		rw_eff   = row_q;
		slot_eff = slot_q;
		if (in_item.frame_start || 12'(col_q) >= wr_lim) c_eff = '0;
		if (in_item.frame_start || 14'(row_q) >= hr_lim) begin
			rw_eff   = '0;
			slot_eff = '0;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign in_image = (c_eff < width_q) && (rw_eff < height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (cfg_wr) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			// advance the raster, wrap column then row
			if (12'(c_eff) + 12'd1 >= wr_lim) begin
				col_q <= '0;
				if (14'(rw_eff) + 14'd1 >= hr_lim) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= rw_eff + 13'd1;
					slot_q <= (slot_eff == 4'(ROW_SLOTS - 1)) ? 4'd0 : slot_eff + 4'd1;
				end
			end else begin
				col_q <= c_eff + 11'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1    <= c_eff;
			rw_s1   <= rw_eff;
			slot_s1 <= slot_eff;
			pix_s1  <= in_item.padding ? 16'd0 : in_item.pixel;
		end
	end

	// line store: one RAM per row slot, all read at the current column
	for (genvar i = 0; i < ROW_SLOTS; i++) begin : g_slot
		bmf_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (accept && in_image && slot_eff == 4'(i)),
			.waddr(c_eff[9:0]),
			.wdata(in_item.padding ? 16'd0 : in_item.pixel),
			.raddr(c_eff[9:0]),
			.rdata(rd_data[i])
		);
	end

	// vertical sum at the current column over the clipped row span
	always_comb begin
		logic [3:0] s;
		logic [15:0] v;
		col_sum  = '0;
		row_keep = '0;
		for (int j = 0; j < ROW_SLOTS; j++) begin
			s = (slot_s1 >= 4'(j)) ? slot_s1 - 4'(j) : slot_s1 + 4'(ROW_SLOTS - j);
			row_keep[j] = (4'(j) <= {radius_q, 1'b0}) && (13'(j) <= rw_s1)
				&& (14'(rw_s1) < {1'b0, height_q} + 14'(j));
			v = '0;
			for (int i = 0; i < ROW_SLOTS; i++) begin
				if (4'(i) == s) v = (j == 0) ? pix_s1 : rd_data[i];
			end
			if (row_keep[j]) col_sum = col_sum + COL_W'(v);
		end
	end

	// column chain: cell k holds the column sum of column c-k
	for (genvar k = 0; k < ROW_SLOTS; k++) begin : g_cell
		assign col_keep[k] = (4'(k) <= {radius_q, 1'b0}) && (11'(k) <= c_s1)
			&& (12'(c_s1) < {1'b0, width_q} + 12'(k));
		assign cell_ctl[k] = '{shift: (state_q == ST_READ), keep: col_keep[k]};
		if (k == 0) begin : g_head
			assign cell_val[k] = col_sum;
		end else begin : g_link
			assign cell_val[k] = cell_out[k-1];
		end
		bmf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl[k]),
			.din    (cell_val[k]),
			.dout   (cell_out[k]),
			.contrib(contrib[k])
		);
	end

	// horizontal sum over kept cells
	always_comb begin
		row_sum = '0;
		for (int k = 0; k < ROW_SLOTS; k++) begin
			row_sum = row_sum + SUM_W'(contrib[k]);
		end
	end

	assign area_full = {4'd0, nrows_q} * {4'd0, 4'($countones(col_keep))};
	assign emit      = (c_s1 >= 11'(radius_q)) && (rw_s1 >= 13'(radius_q));
	assign div_start = (state_q == ST_SUM) && emit;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			nrows_q <= 4'($countones(row_keep));
		end
		if (state_q == ST_SUM) begin
			area_q <= area_full[AREA_W-1:0];
		end
	end

	bmf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(row_sum),
		.divisor (area_full[AREA_W-1:0]),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_READ;
				ST_READ: state_q <= ST_SUM;
				ST_SUM:  state_q <= emit ? ST_DIV : ST_IDLE;
				ST_DIV:  if (div_done) state_q <= ST_DONE;
				ST_DONE: if (!out_valid || out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: load when the slot is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			out_item.mean_value    <= quotient[15:0];
			out_item.out_column    <= 10'(c_s1 - 11'(radius_q));
			out_item.out_row       <= 12'(rw_s1 - 13'(radius_q));
			out_item.last_of_frame <= (c_s1 - 11'(radius_q) == width_q - 11'd1)
				&& (rw_s1 - 13'(radius_q) == height_q - 13'd1);
		end
	end

	`BMF_ASSERT(a_accept_reads, accept |=> state_q == ST_READ, "accept did not start a read")
	`BMF_ASSERT(a_area_nonzero, state_q == ST_DIV |-> area_q != '0, "zero window area")
	`BMF_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(state_q) == ST_DONE, "late raise")
	`BMF_NEVER(a_done_in_div, div_done && state_q != ST_DIV, "divider done while not dividing")
endmodule

[hw/rtl/bmf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/bmf_cell.sv]
// One column cell of the window chain: holds a column sum, hands it on.
// Depends on bmf_pkg.
module bmf_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bmf_pkg::cell_ctl_t          ctl,
	input  logic [bmf_pkg::COL_W-1:0]   din,
	output logic [bmf_pkg::COL_W-1:0]   dout,
	output logic [bmf_pkg::COL_W-1:0]   contrib
);
	import bmf_pkg::*;

	logic [COL_W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctl.shift) begin
			val_q <= din;
		end
	end

	assign dout    = val_q;
	assign contrib = ctl.keep ? val_q : '0;
endmodule

[hw/rtl/bmf_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on bmf_pkg.
module bmf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bmf_pkg::SUM_W-1:0]    dividend,
	input  logic [bmf_pkg::AREA_W-1:0]   divisor,
	output logic                         done,
	output logic [bmf_pkg::SUM_W-1:0]    quotient
);
	import bmf_pkg::*;

	logic [SUM_W-1:0]  q_q;
	logic [AREA_W:0]   rem_q;
	logic [AREA_W-1:0] dvs_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic [AREA_W:0]   trial;
	logic              fits;

	assign trial = {rem_q[AREA_W-1:0], q_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(SUM_W - 1);
			end else if (busy_q) begin
				// retire when the last quotient bit goes in
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			q_q   <= {q_q[SUM_W-2:0], fits};
		end
	end

	assign quotient = q_q;
endmodule

[verif/box_mean_filter_top_tb.sv]
// Self-checking testbench for the box mean filter top level.
// Depends on bmf_pkg and box_mean_filter_top; predicts each mean in the bench.
`timescale 1ns / 100ps

module box_mean_filter_top_tb;
	import bmf_pkg::*;

	localparam int SETTLE_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_item;
	logic        out_valid;
	logic        out_ready;
	out_t        out_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Shadow copy of the block: configuration, position and line store.
	int unsigned img_w, img_h, win_r;
	int unsigned col_pos, row_pos;
	logic [15:0] row_store [ROW_SLOTS][MAX_WIDTH];

	out_t        mean_queue[$];
	int          fail_count;
	int          means_seen;
	int          means_predicted;
	int          requests_sent;
	bit          long_hold;
	bit          stall_enable;

	box_mean_filter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	initial begin
		#200ms;
		$display("timeout after %0d requests, %0d means", requests_sent, means_seen);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report(input string what);
		fail_count++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic int unsigned clamp(input int unsigned v, lo, hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Advance the shadow block by one request and queue the mean it causes.
	function automatic void predict_mean(input in_t req);
		int unsigned c, rw, x, y, x0, x1, y0, y1, total, area;
		out_t m;
		if (req.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= img_w + win_r) col_pos = 0;
		if (row_pos >= img_h + win_r) row_pos = 0;
		c = col_pos;
		rw = row_pos;
		if (c < img_w && rw < img_h)
			row_store[rw % ROW_SLOTS][c] = req.padding ? 16'd0 : req.pixel;
		if (c >= win_r && rw >= win_r) begin
			x = c - win_r;
			y = rw - win_r;
			x0 = (x >= win_r) ? x - win_r : 0;
			x1 = (x + win_r < img_w) ? x + win_r : img_w - 1;
			y0 = (y >= win_r) ? y - win_r : 0;
			y1 = (y + win_r < img_h) ? y + win_r : img_h - 1;
			total = 0;
			for (int unsigned yy = y0; yy <= y1; yy++)
				for (int unsigned xx = x0; xx <= x1; xx++)
					total += row_store[yy % ROW_SLOTS][xx];
			area = (x1 - x0 + 1) * (y1 - y0 + 1);
			m.mean_value = 16'(total / area);
			m.out_column = 10'(x);
			m.out_row = 12'(y);
			m.last_of_frame = (x == img_w - 1 && y == img_h - 1);
			mean_queue.insert(mean_queue.size(), m);
			means_predicted++;
		end
		col_pos = c + 1;
		if (col_pos >= img_w + win_r) begin
			col_pos = 0;
			row_pos = rw + 1;
			if (row_pos >= img_h + win_r) row_pos = 0;
		end
	endfunction

	// Compare every accepted mean with the oldest one predicted.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			means_seen++;
			if (mean_queue.size() == 0) begin
				report($sformatf("unexpected mean %h", out_item));
			end else begin
				out_t e;
				e = mean_queue.pop_front();
				if (out_item.mean_value !== e.mean_value)
					report($sformatf("mean at (%0d,%0d): got %0d want %0d", e.out_column,
						e.out_row, out_item.mean_value, e.mean_value));
				if (out_item.out_column !== e.out_column)
					report($sformatf("column: got %0d want %0d", out_item.out_column,
						e.out_column));
				if (out_item.out_row !== e.out_row)
					report($sformatf("row: got %0d want %0d", out_item.out_row, e.out_row));
				if (out_item.last_of_frame !== e.last_of_frame)
					report($sformatf("last flag at (%0d,%0d): got %b", e.out_column,
						e.out_row, out_item.last_of_frame));
			end
		end
	end

	// Receiver: stall on its own pattern, or hold off for a long stretch.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end
			if (!stall_enable) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Write one register through the APB port and mirror it in the shadow.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH:  img_w = clamp(val & 32'h7FF, 1, MAX_WIDTH);
			REG_HEIGHT: img_h = clamp(val & 32'h1FFF, 1, MAX_HEIGHT);
			REG_RADIUS: win_r = clamp(val & 32'h7, 0, MAX_RADIUS);
			default: ;
		endcase
		col_pos = 0;
		row_pos = 0;
	endtask

	// Offer one request and hold it until it is taken.
	task automatic send(input in_t req);
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_mean(req);
		requests_sent++;
	endtask

	task automatic idle_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// Drain: wait for every predicted mean, then let the pipe settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (mean_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Send one full virtual frame; content random, all ones or random black and white by mode, with some padding noise.
	task automatic send_frame(input int mode);
		int unsigned vw, vh, burst;
		in_t req;
		vw = img_w + win_r;
		vh = img_h + win_r;
		burst = $urandom_range(1, 12);
		for (int unsigned r = 0; r < vh; r++)
			for (int unsigned c = 0; c < vw; c++) begin
				req.frame_start = (r == 0 && c == 0);
				req.padding = (c >= img_w || r >= img_h);
				case (mode)
					0: req.pixel = 16'($urandom);
					1: req.pixel = 16'hFFFF;
					default: req.pixel = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
				endcase
				// Noise: padding inside the image, or a real pixel past its edge.
				if ($urandom_range(0, 19) == 0) req.padding = ~req.padding;
				send(req);
				if (--burst == 0) begin
					if (stall_enable) idle_gap();
					burst = $urandom_range(1, 12);
				end
			end
	endtask

	typedef struct {
		in_t         req;
		bit          checked;
		logic [15:0] mean;
	} row_t;

	initial begin
		row_t plan[$];
		in_t req;
		int idx;
		int rounds;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		long_hold = 0;
		stall_enable = 0;
		img_w = 1024;
		img_h = 1024;
		win_r = 1;
		col_pos = 0;
		row_pos = 0;
		rounds = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: 2x2 image, radius 1; four corners each see the whole frame,
		// three full pixels and one padded, so every mean is 3*65535/4.
		write_reg(REG_WIDTH, 32'd2);
		write_reg(REG_HEIGHT, 32'd2);
		write_reg(REG_RADIUS, 32'd1);
		plan.insert(plan.size(), '{'{16'hFFFF, 1'b0, 1'b1}, 0, 0});
		plan.insert(plan.size(), '{'{16'hFFFF, 1'b0, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'hFFFF, 1'b0, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0001, 1'b1, 1'b0}, 1, 16'hBFFF});
		plan.insert(plan.size(), '{'{16'h0003, 1'b0, 1'b0}, 1, 16'hBFFF});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 1, 16'hBFFF});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 1, 16'hBFFF});
		// Second frame with no frame start: the position wraps on its own.
		plan.insert(plan.size(), '{'{16'h0000, 1'b0, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0000, 1'b0, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0000, 1'b0, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0000, 1'b0, 1'b0}, 1, 16'h0000});
		plan.insert(plan.size(), '{'{16'h0000, 1'b0, 1'b0}, 1, 16'h0000});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 0, 0});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 1, 16'h0000});
		plan.insert(plan.size(), '{'{16'h0000, 1'b1, 1'b0}, 1, 16'h0000});
		foreach (plan[i]) begin
			idx = means_predicted;
			send(plan[i].req);
			// Where a table value is typed in, check that a mean was predicted and that it matches.
			if (plan[i].checked) begin
				if (means_predicted == idx)
					report($sformatf("directed row %0d gave no mean", i));
				else if (mean_queue[$].mean_value !== plan[i].mean)
					report($sformatf("directed row %0d predicted %0d", i,
						mean_queue[$].mean_value));
			end
		end
		drain();

		// Radius 0 on a 1x1 image: each request is its own mean.
		write_reg(REG_RADIUS, 32'd0);
		write_reg(REG_WIDTH, 32'd1);
		write_reg(REG_HEIGHT, 32'd1);
		for (int i = 0; i < 4; i++) begin
			req = '{16'($urandom), 1'($urandom), 1'($urandom)};
			send(req);
		end
		drain();

		// Saturating writes: zero clamps up, oversize clamps down.
		write_reg(REG_WIDTH, 32'd0);
		write_reg(REG_HEIGHT, 32'd0);
		write_reg(REG_RADIUS, 32'd7);
		send_frame(1);
		drain();
		write_reg(REG_WIDTH, 32'hFFFF_FFFF);
		write_reg(REG_HEIGHT, 32'hFFFF_FFFF);
		write_reg(REG_RADIUS, 32'd4);
		// Start of one row of a wide image; cut off by the next config write.
		for (int i = 0; i < 40; i++) send('{16'($urandom), 1'b0, (i == 0)});
		drain();

		// Random frames of small sizes with random idling.
		stall_enable = 1;
		while (requests_sent < 1850) begin
			write_reg(REG_WIDTH, $urandom_range(1, 9));
			write_reg(REG_HEIGHT, $urandom_range(1, 9));
			write_reg(REG_RADIUS, $urandom_range(0, 4));
			if (rounds == 0 || $urandom_range(0, 3) == 0) long_hold = 1;
			rounds++;
			send_frame($urandom_range(0, 2));
			if ($urandom_range(0, 1)) send_frame(0);
			drain();
		end
		drain();

		$display("covered %0d requests and %0d means over widths, heights and radii",
			requests_sent, means_seen);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
